// ----- design/segmented_tx_byte_queue_defines.svh -----
// ---------------------------------------------------------------------------
// Segmented transmit byte queue: assertion macros
// Shared property forms for clk/rst based checks.
// ---------------------------------------------------------------------------
`ifndef SEGMENTED_TX_BYTE_QUEUE_DEFINES_SVH
`define SEGMENTED_TX_BYTE_QUEUE_DEFINES_SVH

// same-cycle implication
`define SEGTXQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEGTXQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/segtxq_pkg.sv -----
// ---------------------------------------------------------------------------
// Segmented transmit byte queue: package
// Sizes, codes and beat types shared by the queue modules.
// ---------------------------------------------------------------------------
package segtxq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int SEG_MAX     = 32;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W  = $clog2(SEG_MAX + 1);
  localparam int CNT_W  = 16;
  localparam int SENT_W = 29;

  localparam logic [SENT_W-1:0] SENT_STOP = 29'h0FFF_FFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;

  typedef enum logic {
    MODE_PUSH    = 1'b0,
    MODE_SERVICE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RETRY = 2'd1,
    STATUS_ERROR = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_SEND
  } state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       kick;
    logic       link_free;
    logic [1:0] start_status;
  } item_t;

  typedef struct packed {
    logic              seg_valid;
    logic [7:0]        seg_byte;
    logic              seg_last;
    logic              byte_accepted;
    logic              segment_started;
    logic [FILL_W-1:0] pending_count;
    logic [CNT_W-1:0]  drop_count;
    logic [CNT_W-1:0]  error_count;
    logic [SENT_W-1:0] sent_count;
  } result_t;

endpackage

// ----- design/segtxq_ram.sv -----
// ---------------------------------------------------------------------------
// Segmented transmit byte queue: byte store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module segtxq_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [segtxq_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic [segtxq_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                    rdata
);
  import segtxq_pkg::*;

  logic [7:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/segmented_tx_byte_queue.sv -----
// ---------------------------------------------------------------------------
// Segmented transmit byte queue
// Byte FIFO with segment peek, retry and saturating status counters.
// ---------------------------------------------------------------------------
// Usage: the item channel (item_valid/item_ready/item) carries push or
// service beats; the result channel (result_valid/result_ready/result)
// returns result beats with the counters after the step.
// A push without a transfer gives one result beat, registered, in the cycle
// after acceptance; with the receiver ready one item is taken per cycle.
// A transfer attempt emits min(fill, 32) byte beats: S_PRIME primes the store
// read, then one beat per cycle while the receiver is ready, set by the single
// read port of the byte store. Items are held off until the last segment beat is loaded.
// Reset clears pointers, fill level and counters; stored bytes are not
// cleared and need no clearing pass.
// When the receiver stalls, the result register holds its beat, the store
// read is repeated in place and no new item is taken.
// ---------------------------------------------------------------------------
module segmented_tx_byte_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  segtxq_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output segtxq_pkg::result_t result
);
  import segtxq_pkg::*;

  `include "segmented_tx_byte_queue_defines.svh"

  state_t            state, state_next;
  logic [ADDR_W-1:0] rd_ptr, rd_ptr_next;
  logic [ADDR_W-1:0] wr_ptr, wr_ptr_next;
  logic [FILL_W-1:0] fill_level, fill_level_next;
  logic [CNT_W-1:0]  drop_total, drop_total_next;
  logic [CNT_W-1:0]  err_total, err_total_next;
  logic [SENT_W-1:0] sent_total, sent_total_next;
  logic [ADDR_W-1:0] seg_ptr, seg_ptr_next;
  logic [LEN_W-1:0]  seg_cnt, seg_cnt_next;
  logic              acc_flag, acc_flag_next;
  logic              start_flag, start_flag_next;
  logic              result_valid_next;
  result_t           result_next;

  logic              accept, is_push, full, push_ok, attempt, pop, out_free, out_load;
  logic [FILL_W-1:0] fill_push;
  logic [LEN_W-1:0]  seg_len;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  segtxq_ram u_ram (
    .clk   (clk),
    .we    (accept && push_ok),
    .waddr (wr_ptr),
    .wdata (item.data_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE) && out_free;
  assign accept     = item_valid && item_ready;
  assign is_push    = item.mode == MODE_PUSH;
  assign full       = fill_level == FILL_W'(QUEUE_DEPTH);
  assign push_ok    = is_push && !full;
  assign fill_push  = fill_level + FILL_W'(push_ok);
  assign attempt    = (!is_push || item.kick) && item.link_free && (fill_push != '0);
  assign seg_len    = (fill_push > FILL_W'(SEG_MAX)) ? LEN_W'(SEG_MAX)
                                                     : fill_push[LEN_W-1:0];
  assign pop        = attempt && (item.start_status == STATUS_OK);

  always_comb begin
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    fill_level_next = fill_level;
    drop_total_next = drop_total;
    err_total_next  = err_total;
    sent_total_next = sent_total;
    if (accept) begin
      if (push_ok) begin
        wr_ptr_next = wr_ptr + ADDR_W'(1);
      end else if (is_push && (drop_total < CNT_MAX)) begin
        drop_total_next = drop_total + CNT_W'(1);
      end
      fill_level_next = fill_push;
      if (pop) begin
        rd_ptr_next     = rd_ptr + ADDR_W'(seg_len);
        fill_level_next = fill_push - FILL_W'(seg_len);
        if (sent_total < SENT_STOP) begin
          sent_total_next = sent_total + SENT_W'(seg_len);
        end
      end else if (attempt && (item.start_status == STATUS_ERROR) &&
                   (err_total < CNT_MAX)) begin
        err_total_next = err_total + CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next        = state;
    seg_ptr_next      = seg_ptr;
    seg_cnt_next      = seg_cnt;
    acc_flag_next     = acc_flag;
    start_flag_next   = start_flag;
    raddr             = seg_ptr;
    out_load          = 1'b0;
    result_next       = result;
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          acc_flag_next   = push_ok;
          start_flag_next = pop;
          if (attempt) begin
            seg_ptr_next = rd_ptr;
            seg_cnt_next = seg_len;
            state_next   = S_PRIME;
          end else begin
            out_load                    = 1'b1;
            result_next.seg_valid       = 1'b0;
            result_next.seg_byte        = '0;
            result_next.seg_last        = 1'b1;
            result_next.byte_accepted   = push_ok;
            result_next.segment_started = 1'b0;
            result_next.pending_count   = fill_level_next;
            result_next.drop_count      = drop_total_next;
            result_next.error_count     = err_total_next;
            result_next.sent_count      = sent_total_next;
          end
        end
      end
      S_PRIME: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          out_load                    = 1'b1;
          raddr                       = seg_ptr + ADDR_W'(1);
          seg_ptr_next                = seg_ptr + ADDR_W'(1);
          seg_cnt_next                = seg_cnt - LEN_W'(1);
          result_next.seg_valid       = 1'b1;
          result_next.seg_byte        = rdata;
          result_next.seg_last        = seg_cnt == LEN_W'(1);
          result_next.byte_accepted   = acc_flag;
          result_next.segment_started = start_flag;
          result_next.pending_count   = fill_level;
          result_next.drop_count      = drop_total;
          result_next.error_count     = err_total;
          result_next.sent_count      = sent_total;
          if (seg_cnt == LEN_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (out_load) begin
      result_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      fill_level   <= '0;
      drop_total   <= '0;
      err_total    <= '0;
      sent_total   <= '0;
      seg_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rd_ptr       <= rd_ptr_next;
      wr_ptr       <= wr_ptr_next;
      fill_level   <= fill_level_next;
      drop_total   <= drop_total_next;
      err_total    <= err_total_next;
      sent_total   <= sent_total_next;
      seg_cnt      <= seg_cnt_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    seg_ptr    <= seg_ptr_next;
    acc_flag   <= acc_flag_next;
    start_flag <= start_flag_next;
    result     <= result_next;
  end

  `SEGTXQ_ASSERT_IMPL(a_busy_blocks_items, state != S_IDLE, !item_ready,
                      "item taken while a segment is in flight")
  `SEGTXQ_ASSERT_IMPL(a_send_count, state == S_SEND, seg_cnt != '0,
                      "segment beat count exhausted in send")
  `SEGTXQ_ASSERT_IMPL(a_ptr_fill, 1'b1, (wr_ptr - rd_ptr) == fill_level[ADDR_W-1:0],
                      "pointers disagree with fill level")
  `SEGTXQ_ASSERT_NEXT(a_drop_holds_wr, accept && is_push && full, wr_ptr == $past(wr_ptr),
                      "write pointer moved on a dropped byte")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Segmented transmit byte queue testbench
// Pushes bytes and service attempts through the item channel. A shadow copy
// of the queue and its counters predicts every result beat, and each beat
// that comes back is checked field by field in order. Covers empty, busy-link,
// retry, error and reserved-status attempts, queue overflow with drops, and
// long receiver stalls, with random idling on both sides.
// ---------------------------------------------------------------------------
module testbench;
  import segtxq_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 320;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  logic        item_fire = 1'b0;
  bit          calm = 1'b0;
  int unsigned hold_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned quiet_cycles = 0;
  int unsigned staged = 0;
  int          mismatches = 0;

  item_t   offered_items[$];
  result_t beats_due[$];

  logic [7:0]        shadow_bytes [QUEUE_DEPTH];
  logic [ADDR_W-1:0] shadow_head = '0;
  logic [ADDR_W-1:0] shadow_tail = '0;
  logic [FILL_W-1:0] shadow_fill = '0;
  logic [CNT_W-1:0]  shadow_drops = '0;
  logic [CNT_W-1:0]  shadow_errors = '0;
  logic [SENT_W-1:0] shadow_sent = '0;

  segmented_tx_byte_queue dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic advance_tx_queue(input item_t it);
    bit                accepted;
    bit                attempt;
    bit                started;
    int unsigned       seg_len;
    logic [ADDR_W-1:0] peek;
    result_t           beat;
    accepted = 1'b0;
    started  = 1'b0;
    if (it.mode == MODE_PUSH) begin
      if (shadow_fill < QUEUE_DEPTH) begin
        shadow_bytes[shadow_tail] = it.data_byte;
        shadow_tail = shadow_tail + 1'b1;
        shadow_fill = shadow_fill + 1'b1;
        accepted = 1'b1;
      end else if (shadow_drops != CNT_MAX) begin
        shadow_drops = shadow_drops + 1'b1;
      end
      attempt = it.kick;
    end else begin
      attempt = 1'b1;
    end
    beat = '0;
    beat.byte_accepted = accepted;
    if (!attempt || !it.link_free || shadow_fill == 0) begin
      beat.seg_last      = 1'b1;
      beat.pending_count = shadow_fill;
      beat.drop_count    = shadow_drops;
      beat.error_count   = shadow_errors;
      beat.sent_count    = shadow_sent;
      beats_due.push_back(beat);
    end else begin
      seg_len = (shadow_fill > SEG_MAX) ? SEG_MAX : shadow_fill;
      peek = shadow_head;
      case (it.start_status)
        STATUS_OK: begin
          shadow_head = shadow_head + ADDR_W'(seg_len);
          shadow_fill = shadow_fill - FILL_W'(seg_len);
          if (shadow_sent < SENT_STOP) shadow_sent = shadow_sent + SENT_W'(seg_len);
          started = 1'b1;
        end
        STATUS_ERROR: begin
          if (shadow_errors != CNT_MAX) shadow_errors = shadow_errors + 1'b1;
        end
        default: begin
        end
      endcase
      for (int unsigned i = 0; i < seg_len; i++) begin
        beat.seg_valid       = 1'b1;
        beat.seg_byte        = shadow_bytes[peek];
        beat.seg_last        = (i + 1 == seg_len);
        beat.segment_started = started;
        beat.pending_count   = shadow_fill;
        beat.drop_count      = shadow_drops;
        beat.error_count     = shadow_errors;
        beat.sent_count      = shadow_sent;
        beats_due.push_back(beat);
        peek = peek + 1'b1;
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !item_fire) begin
      // hold the beat until it is taken
    end else if (offered_items.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
      item_valid <= 1'b1;
      item       <= offered_items.pop_front();
    end else begin
      item_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served  <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      item_fire    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      item_fire <= item_valid && item_ready;
      if (item_valid && item_ready) advance_tx_queue(item);
      if (result_valid && result_ready) begin
        if (beats_due.size() == 0) begin
          $error("unexpected result beat: %p", result);
          mismatches++;
        end else begin
          want = beats_due.pop_front();
          if (result.seg_valid !== want.seg_valid) begin
            $error("seg_valid: expected %0d, got %0d", want.seg_valid, result.seg_valid);
            mismatches++;
          end
          if (result.seg_byte !== want.seg_byte) begin
            $error("seg_byte: expected %0h, got %0h", want.seg_byte, result.seg_byte);
            mismatches++;
          end
          if (result.seg_last !== want.seg_last) begin
            $error("seg_last: expected %0d, got %0d", want.seg_last, result.seg_last);
            mismatches++;
          end
          if (result.byte_accepted !== want.byte_accepted) begin
            $error("byte_accepted: expected %0d, got %0d", want.byte_accepted,
                   result.byte_accepted);
            mismatches++;
          end
          if (result.segment_started !== want.segment_started) begin
            $error("segment_started: expected %0d, got %0d", want.segment_started,
                   result.segment_started);
            mismatches++;
          end
          if (result.pending_count !== want.pending_count) begin
            $error("pending_count: expected %0d, got %0d", want.pending_count,
                   result.pending_count);
            mismatches++;
          end
          if (result.drop_count !== want.drop_count) begin
            $error("drop_count: expected %0d, got %0d", want.drop_count, result.drop_count);
            mismatches++;
          end
          if (result.error_count !== want.error_count) begin
            $error("error_count: expected %0d, got %0d", want.error_count, result.error_count);
            mismatches++;
          end
          if (result.sent_count !== want.sent_count) begin
            $error("sent_count: expected %0h, got %0h", want.sent_count, result.sent_count);
            mismatches++;
          end
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic status_t pick_status();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return STATUS_OK;
    if (roll < 70) return STATUS_RETRY;
    if (roll < 90) return STATUS_ERROR;
    return STATUS_RSVD;
  endfunction

  task automatic stage(input mode_t m, input logic [7:0] d, input logic k, input logic lf,
                       input status_t st);
    item_t it;
    it.mode         = m;
    it.data_byte    = d;
    it.kick         = k;
    it.link_free    = lf;
    it.start_status = st;
    offered_items.push_back(it);
    staged++;
  endtask

  task automatic stage_message(input int unsigned n);
    for (int unsigned i = 1; i <= n; i++) begin
      if (i == n)
        stage(MODE_PUSH, 8'($urandom), 1'b1, $urandom_range(0, 9) != 0, pick_status());
      else
        stage(MODE_PUSH, 8'($urandom), 1'b0, 1'($urandom), pick_status());
    end
  endtask

  task automatic stage_traffic(input int unsigned n);
    int unsigned stop;
    int unsigned len;
    stop = staged + n;
    while (staged < stop) begin
      case ($urandom_range(0, 19))
        0, 1, 2: stage(mode_t'(1'($urandom)), 8'($urandom), 1'($urandom), 1'($urandom),
                       status_t'(2'($urandom)));
        3, 4:    stage(MODE_SERVICE, 8'($urandom), 1'($urandom), $urandom_range(0, 4) != 0,
                       pick_status());
        default: begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 70)
                                            : $urandom_range(1, 12);
          if (len > stop - staged) len = stop - staged;
          stage_message(len);
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    while (offered_items.size() != 0 || item_valid || beats_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    stage(MODE_SERVICE, 8'h00, 1'b0, 1'b1, STATUS_OK);
    stage(MODE_PUSH,    8'h00, 1'b0, 1'b1, STATUS_OK);
    stage(MODE_PUSH,    8'hFF, 1'b1, 1'b0, STATUS_OK);
    stage(MODE_PUSH,    8'hA5, 1'b1, 1'b1, STATUS_RETRY);
    stage(MODE_SERVICE, 8'hFF, 1'b1, 1'b1, STATUS_ERROR);
    stage(MODE_SERVICE, 8'h3C, 1'b0, 1'b1, STATUS_RSVD);
    stage(MODE_SERVICE, 8'h00, 1'b1, 1'b0, STATUS_OK);
    stage(MODE_SERVICE, 8'h00, 1'b0, 1'b1, STATUS_OK);
    stage(MODE_PUSH,    8'h5A, 1'b0, 1'b0, STATUS_ERROR);
    stage(MODE_PUSH,    8'h01, 1'b1, 1'b1, STATUS_OK);
    stage(MODE_PUSH,    8'h80, 1'b1, 1'b1, STATUS_OK);
    stage(MODE_PUSH,    8'h7F, 1'b1, 1'b1, STATUS_ERROR);
    stage(MODE_SERVICE, 8'hFF, 1'b1, 1'b1, STATUS_OK);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    stage_traffic(16);
    wait_idle();

    // stall the receiver, then overflow the queue, with no idling
    calm = 1'b1;
    hold_asked++;
    repeat (QUEUE_DEPTH - int'(shadow_fill) + 3) begin
      if ($urandom_range(0, 19) == 0)
        stage(MODE_PUSH, 8'($urandom), 1'b1, 1'b0, status_t'(2'($urandom)));
      else
        stage(MODE_PUSH, 8'($urandom), 1'b0, 1'($urandom), status_t'(2'($urandom)));
    end
    wait_idle();
    calm = 1'b0;

    repeat (10) stage(MODE_SERVICE, 8'($urandom), 1'($urandom), 1'b1, pick_status());
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && beats_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/segtxq_pkg.sv
design/segtxq_ram.sv
design/segmented_tx_byte_queue.sv
dv/testbench.sv
